// ----- hw/rtl/lbft_pkg.sv -----
// shared constants, types and codes for the learning bridge forwarding table
`default_nettype none
package lbft_pkg;

    localparam int DYN_ENTRIES    = 1024;
    localparam int STATIC_ENTRIES = 64;

    localparam int DYN_AW    = (DYN_ENTRIES > 1) ? $clog2(DYN_ENTRIES) : 1;
    localparam int STAT_AW   = (STATIC_ENTRIES > 1) ? $clog2(STATIC_ENTRIES) : 1;
    localparam int SWEEP_LEN = (DYN_ENTRIES > STATIC_ENTRIES) ? DYN_ENTRIES : STATIC_ENTRIES;
    localparam int CNT_W     = $clog2(SWEEP_LEN + 1);

    localparam int MAC_W  = 48;
    localparam int PORT_W = 8;
    localparam int TIME_W = 32;
    localparam int PADDR_W = 3;

    typedef logic [2:0] verdict_t;
    localparam verdict_t V_FORWARD  = 3'd0;
    localparam verdict_t V_FLOOD    = 3'd1;
    localparam verdict_t V_FILTERED = 3'd2;
    localparam verdict_t V_STORED   = 3'd3;
    localparam verdict_t V_FULL     = 3'd4;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_RULE  = 1'b1;

    localparam logic [PADDR_W-1:0] REG_AGE_LIMIT = 3'd0;
    localparam logic [TIME_W-1:0]  AGE_LIMIT_RST = 32'd300;

    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] last_seen;
    } dyn_entry_t;

    typedef struct packed {
        logic [MAC_W-1:0]  addr;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic              filter;
    } stat_entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lbft_in_if.sv -----
// request channel carrying frames and static rule writes
`default_nettype none
interface lbft_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [lbft_pkg::PORT_W-1:0]   in_port;
    logic [lbft_pkg::MAC_W-1:0]    src_mac;
    logic [lbft_pkg::MAC_W-1:0]    dst_mac;
    logic [lbft_pkg::TIME_W-1:0]   now;
    logic [lbft_pkg::PORT_W-1:0]   rule_out_port;
    logic                          rule_filter;

    modport source (output valid, cmd, in_port, src_mac, dst_mac, now, rule_out_port,
                    rule_filter, input ready);
    modport sink (input valid, cmd, in_port, src_mac, dst_mac, now, rule_out_port,
                  rule_filter, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lbft_out_if.sv -----
// result channel carrying the forwarding verdict
`default_nettype none
interface lbft_out_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  verdict;
    logic [lbft_pkg::PORT_W-1:0] out_port;
    logic                        learn_failed;

    modport source (output valid, verdict, out_port, learn_failed, input ready);
    modport sink (input valid, verdict, out_port, learn_failed, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/learning_bridge_forwarding_table_top.sv -----
// learning bridge: dynamic table with aging, static rule table, apb register port
// flow: a request is accepted in idle, then the sweep state reads every entry and the finish
// state registers the result, waiting only while an earlier result is still held by a low ready
// a new request is taken only in idle, once the last one is through; every request sweeps the entry
// memories one read a cycle, since aging, learning and lookup each need a look at every entry
// reset: age_limit goes to 300, static valid bits clear at once, then a clearing pass writes every
// dynamic entry invalid before the first request is accepted
`default_nettype none
module learning_bridge_forwarding_table_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    lbft_in_if.sink                                 in_ch,
    lbft_out_if.source                              out_ch,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lbft_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready
);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SWEEP, ST_FINISH} state_t;

    localparam int CW = lbft_pkg::CNT_W;
    localparam int DA = lbft_pkg::DYN_AW;
    localparam int SA = lbft_pkg::STAT_AW;

    // entry memories, one read and one write port each
    lbft_pkg::dyn_entry_t  dyn_mem  [lbft_pkg::DYN_ENTRIES];
    lbft_pkg::stat_entry_t stat_mem [lbft_pkg::STATIC_ENTRIES];

    state_t                        state_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          rd_vld_reg;
    logic [CW-1:0]                 rd_idx_reg;
    lbft_pkg::dyn_entry_t          dyn_rd_reg;
    lbft_pkg::stat_entry_t         stat_rd_reg;
    logic                          stat_v_rd_reg;
    logic [lbft_pkg::STATIC_ENTRIES-1:0] stat_valid_reg;
    logic [31:0]                   age_limit_reg;

    // latched request
    logic                          cmd_reg;
    logic [7:0]                    port_reg;
    logic [47:0]                   src_reg;
    logic [47:0]                   dst_reg;
    logic [31:0]                   now_reg;
    logic [7:0]                    rport_reg;
    logic                          rfilt_reg;
    logic                          age_en_reg;
    logic [31:0]                   oldest_reg;

    // sticky search results, lowest index wins
    logic                          src_hit_reg;
    logic [DA-1:0]                 src_idx_reg;
    logic [7:0]                    src_port_reg;
    logic                          free_hit_reg;
    logic [DA-1:0]                 free_idx_reg;
    logic                          dst_hit_reg;
    logic [7:0]                    dst_port_reg;
    logic                          s_hit_reg;
    logic [SA-1:0]                 s_idx_reg;
    logic [7:0]                    s_dport_reg;
    logic                          s_filt_reg;
    logic                          s_free_reg;
    logic [SA-1:0]                 s_free_idx_reg;

    logic                          out_valid_reg;
    lbft_pkg::verdict_t            verdict_reg;
    logic [7:0]                    out_port_reg;
    logic                          learn_failed_reg;

    logic                          dyn_we;
    logic [DA-1:0]                 dyn_waddr;
    lbft_pkg::dyn_entry_t          dyn_wdata;
    logic                          stat_we;
    logic [SA-1:0]                 stat_waddr;
    logic                          dyn_proc;
    logic                          stat_proc;
    logic                          aged;
    logic                          live;
    logic                          smatch;
    logic                          out_free;
    logic                          accept;
    logic                          cfg_wr;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.verdict      = verdict_reg;
    assign out_ch.out_port     = out_port_reg;
    assign out_ch.learn_failed = learn_failed_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == lbft_pkg::REG_AGE_LIMIT[2]);
    assign prdata = (paddr[2] == lbft_pkg::REG_AGE_LIMIT[2]) ? age_limit_reg : 32'd0;

    // per-entry checks on the data read in the previous cycle
    assign dyn_proc  = rd_vld_reg && (cmd_reg == lbft_pkg::CMD_FRAME)
                       && (rd_idx_reg < CW'(lbft_pkg::DYN_ENTRIES));
    assign stat_proc = rd_vld_reg && (rd_idx_reg < CW'(lbft_pkg::STATIC_ENTRIES));
    assign aged  = dyn_rd_reg.valid && age_en_reg && (dyn_rd_reg.last_seen < oldest_reg);
    assign live  = dyn_rd_reg.valid && !aged;
    assign smatch = stat_v_rd_reg && (stat_rd_reg.addr == dst_reg)
                    && (stat_rd_reg.src_port == port_reg);

    // write port selection: clearing pass, aging write-back, learning, rule store
    always_comb
    begin
        dyn_we    = 1'b0;
        dyn_waddr = rd_idx_reg[DA-1:0];
        dyn_wdata = dyn_rd_reg;
        stat_we   = 1'b0;
        stat_waddr = s_hit_reg ? s_idx_reg : s_free_idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                dyn_we    = 1'b1;
                dyn_waddr = cnt_reg[DA-1:0];
                dyn_wdata = '0;
            end
            ST_SWEEP:
            begin
                if (dyn_proc && aged)
                begin
                    dyn_we          = 1'b1;
                    dyn_wdata.valid = 1'b0;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (cmd_reg == lbft_pkg::CMD_FRAME)
                    begin
                        // known source only refreshes its time, new source takes lowest free slot
                        dyn_we    = src_hit_reg || free_hit_reg;
                        dyn_waddr = src_hit_reg ? src_idx_reg : free_idx_reg;
                        dyn_wdata.valid     = 1'b1;
                        dyn_wdata.addr      = src_reg;
                        dyn_wdata.port      = src_hit_reg ? src_port_reg : port_reg;
                        dyn_wdata.last_seen = now_reg;
                    end
                    else
                    begin
                        stat_we = s_hit_reg || s_free_reg;
                    end
                end
            end
            default:
            begin
                dyn_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dyn_we)
        begin
            dyn_mem[dyn_waddr] <= dyn_wdata;
        end
        dyn_rd_reg <= dyn_mem[cnt_reg[DA-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_waddr] <= '{addr: dst_reg, src_port: port_reg,
                                      dst_port: rport_reg, filter: rfilt_reg};
        end
        stat_rd_reg <= stat_mem[cnt_reg[SA-1:0]];
    end

    // control, search state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            stat_valid_reg <= '0;
            age_limit_reg  <= lbft_pkg::AGE_LIMIT_RST;
        end
        else
        begin
            if (cfg_wr)
            begin
                age_limit_reg <= pwdata;
            end
            // a result taken while the next one is issued is handled in the finish state
            if (out_ch.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            stat_v_rd_reg <= stat_valid_reg[cnt_reg[SA-1:0]];
            case (state_reg)
                ST_CLEAR:
                begin
                    if (cnt_reg == CW'(lbft_pkg::DYN_ENTRIES - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= in_ch.cmd;
                        port_reg   <= in_ch.in_port;
                        src_reg    <= in_ch.src_mac;
                        dst_reg    <= in_ch.dst_mac;
                        now_reg    <= in_ch.now;
                        rport_reg  <= in_ch.rule_out_port;
                        rfilt_reg  <= in_ch.rule_filter;
                        // aging only once now has reached the limit
                        age_en_reg <= (in_ch.now >= age_limit_reg);
                        oldest_reg <= in_ch.now - age_limit_reg;
                        src_hit_reg  <= 1'b0;
                        free_hit_reg <= 1'b0;
                        dst_hit_reg  <= 1'b0;
                        s_hit_reg    <= 1'b0;
                        s_free_reg   <= 1'b0;
                        cnt_reg      <= '0;
                        rd_vld_reg   <= 1'b0;
                        state_reg    <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    if (cnt_reg < CW'(lbft_pkg::SWEEP_LEN))
                    begin
                        rd_vld_reg <= 1'b1;
                        rd_idx_reg <= cnt_reg;
                        cnt_reg    <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        rd_vld_reg <= 1'b0;
                        if (!rd_vld_reg)
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                    if (dyn_proc)
                    begin
                        if (live && (dyn_rd_reg.addr == src_reg) && !src_hit_reg)
                        begin
                            src_hit_reg  <= 1'b1;
                            src_idx_reg  <= rd_idx_reg[DA-1:0];
                            src_port_reg <= dyn_rd_reg.port;
                        end
                        if (!live && !free_hit_reg)
                        begin
                            free_hit_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg[DA-1:0];
                        end
                        if (live && (dyn_rd_reg.addr == dst_reg) && !dst_hit_reg)
                        begin
                            dst_hit_reg  <= 1'b1;
                            dst_port_reg <= dyn_rd_reg.port;
                        end
                    end
                    if (stat_proc)
                    begin
                        if (smatch && !s_hit_reg)
                        begin
                            s_hit_reg   <= 1'b1;
                            s_idx_reg   <= rd_idx_reg[SA-1:0];
                            s_dport_reg <= stat_rd_reg.dst_port;
                            s_filt_reg  <= stat_rd_reg.filter;
                        end
                        if (!stat_v_rd_reg && !s_free_reg)
                        begin
                            s_free_reg     <= 1'b1;
                            s_free_idx_reg <= rd_idx_reg[SA-1:0];
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (cmd_reg == lbft_pkg::CMD_RULE)
                        begin
                            out_port_reg     <= 8'd0;
                            learn_failed_reg <= 1'b0;
                            if (s_hit_reg || s_free_reg)
                            begin
                                verdict_reg <= lbft_pkg::V_STORED;
                                stat_valid_reg[stat_waddr] <= 1'b1;
                            end
                            else
                            begin
                                verdict_reg <= lbft_pkg::V_FULL;
                            end
                        end
                        else
                        begin
                            learn_failed_reg <= !src_hit_reg && !free_hit_reg;
                            if (s_hit_reg)
                            begin
                                verdict_reg  <= s_filt_reg ? lbft_pkg::V_FILTERED
                                                           : lbft_pkg::V_FORWARD;
                                out_port_reg <= s_filt_reg ? port_reg : s_dport_reg;
                            end
                            else if ((dst_reg == src_reg) && (src_hit_reg || free_hit_reg))
                            begin
                                // destination sees the entry just learned or refreshed
                                verdict_reg  <= lbft_pkg::V_FORWARD;
                                out_port_reg <= src_hit_reg ? src_port_reg : port_reg;
                            end
                            else if (dst_hit_reg)
                            begin
                                verdict_reg  <= lbft_pkg::V_FORWARD;
                                out_port_reg <= dst_port_reg;
                            end
                            else
                            begin
                                verdict_reg  <= lbft_pkg::V_FLOOD;
                                out_port_reg <= 8'd0;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lbft_checker.sv -----
// port-level checks for the learning bridge forwarding table
`default_nettype none
module lbft_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] verdict,
    input wire logic [7:0] out_port,
    input wire logic       learn_failed,
    input wire logic       pready
);

    // result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(out_port))
        else $error("result changed while stalled");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict <= lbft_pkg::V_FULL))
        else $error("verdict code out of range");

    a_rule_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == lbft_pkg::V_STORED || verdict == lbft_pkg::V_FULL)
        |-> (out_port == 8'd0) && !learn_failed)
        else $error("rule result carries port or learn failure");

    a_flood_port: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == lbft_pkg::V_FLOOD) |-> (out_port == 8'd0))
        else $error("flood result with nonzero port");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind learning_bridge_forwarding_table_top lbft_checker u_lbft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .verdict      (out_ch.verdict),
    .out_port     (out_ch.out_port),
    .learn_failed (out_ch.learn_failed),
    .pready       (pready)
);
`default_nettype wire
